// File: hdl/trfps_pkg.sv
// Package for the forward traceroute probe sequencer.
// Holds codes, the result record and the result builder; no dependencies.
`default_nettype none

package trfps_pkg;

  localparam int MAX_HOPS_DEF = 32;
  localparam int ADDR_W = 32;
  localparam int TTL_W = 7;
  localparam int FIELD_TTL_W = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] REG_PROBES_PER_HOP = 3'd0;
  localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd1;
  localparam logic [2:0] REG_START_TTL = 3'd2;
  localparam logic [2:0] REG_DEST_ADDR = 3'd3;
  localparam logic [2:0] REG_CMP_ENABLE = 3'd4;
  localparam logic [2:0] REG_CMP_START = 3'd5;
  localparam logic [2:0] REG_CMP_END = 3'd6;
  localparam logic [2:0] REG_CMP_OUTCOME = 3'd7;

  localparam logic [3:0] UNR_PROTOCOL = 4'd2;
  localparam logic [3:0] UNR_PORT = 4'd3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_RESP  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    RSP_TIMEOUT  = 3'd0,
    RSP_EXCEEDED = 3'd1,
    RSP_UNREACH  = 3'd2,
    RSP_FINAL    = 3'd3,
    RSP_FAIL     = 3'd4
  } resp_e;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OUT_REACHED = 3'd0,
    OUT_UNREACH = 3'd1,
    OUT_LOOP    = 3'd2,
    OUT_FAKE    = 3'd3,
    OUT_TIMEOUT = 3'd4,
    OUT_MEETS   = 3'd5,
    OUT_MAXHOP  = 3'd6
  } outcome_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PREV,
    S_LOOP,
    S_DEST,
    S_CMP,
    S_ONE_CHK,
    S_EMIT
  } state_e;

  typedef struct packed {
    kind_e                   kind;
    logic [FIELD_TTL_W-1:0]  probe_ttl;
    logic                    probe_to_dest;
    logic                    hop_valid;
    logic [FIELD_TTL_W-1:0]  hop_ttl;
    logic [ADDR_W-1:0]       hop_address;
    outcome_e                outcome;
    logic [FIELD_TTL_W-1:0]  end_ttl;
  } res_t;

  function automatic res_t mk_res(input kind_e k, input logic [TTL_W-1:0] pttl,
                                  input logic pd, input logic hv,
                                  input logic [TTL_W-1:0] httl,
                                  input logic [ADDR_W-1:0] haddr,
                                  input outcome_e oc, input logic [TTL_W-1:0] endt);
    res_t r;
    r.kind = k;
    r.probe_ttl = pttl[FIELD_TTL_W-1:0];
    r.probe_to_dest = pd;
    r.hop_valid = hv;
    r.hop_ttl = hv ? httl[FIELD_TTL_W-1:0] : '0;
    r.hop_address = hv ? haddr : '0;
    r.outcome = oc;
    r.end_ttl = endt[FIELD_TTL_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/traceroute_forward_probe_sequencer.sv
// Forward traceroute probe sequencer: hop and comparison stores in local RAMs.
// Depends on trfps_pkg.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one beat per
// load, start or probe response; the output channel (out_valid_o /
// out_stall_i) carries at most one result beat per input beat. Loads and
// ignored beats give no result. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i while the block is idle.
// Flow: a load or an ignored beat passes through S_EXEC alone; a start,
// timeout, final reply or failure beat passes S_EXEC and then S_EMIT, which
// loads the output register. A time exceeded beat may walk the hop RAM and
// then the comparison RAM one entry a cycle through their single read ports.
// One beat is in work at a time; in_stall_o stays high until its result is
// handed to the output register. The output register holds a result while
// out_stall_i is high; the next beat is already accepted and worked on, and
// waits to load only if it finishes before the held result leaves.
// Reset clears the control state and the configuration registers to their
// defaults; the data registers and the RAM contents are undefined until written.
`default_nettype none

module traceroute_forward_probe_sequencer #(
  parameter int MAX_HOPS = trfps_pkg::MAX_HOPS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [trfps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [trfps_pkg::ADDR_W-1:0]         cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           action_i,
  input  wire logic [trfps_pkg::FIELD_TTL_W-1:0]    hop_index_i,
  input  wire logic [trfps_pkg::ADDR_W-1:0]         address_i,
  input  wire logic [2:0]                           response_kind_i,
  input  wire logic [3:0]                           unreach_code_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                kind_o,
  output logic [trfps_pkg::FIELD_TTL_W-1:0]         probe_ttl_o,
  output logic                                      probe_to_dest_o,
  output logic                                      hop_valid_o,
  output logic [trfps_pkg::FIELD_TTL_W-1:0]         hop_ttl_o,
  output logic [trfps_pkg::ADDR_W-1:0]              hop_address_o,
  output logic [2:0]                                outcome_o,
  output logic [trfps_pkg::FIELD_TTL_W-1:0]         end_ttl_o
);

  localparam int IW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int TW = trfps_pkg::TTL_W;
  localparam int AW = trfps_pkg::ADDR_W;
  localparam logic [TW-1:0] MAXH = TW'(MAX_HOPS);
  localparam logic [TW-1:0] MAXH1 = TW'(MAX_HOPS + 1);
  localparam logic [TW-1:0] ONE = TW'(1);
  localparam logic [TW-1:0] TWO = TW'(2);

  // configuration
  logic [3:0]    per_q, lim_q;
  logic [5:0]    start_ttl_q, cmp_start_q, cmp_end_q;
  logic [AW-1:0] dest_q;
  logic          cmp_en_q;
  logic [2:0]    cmp_oc_q;

  // item and trace state
  trfps_pkg::state_e state_q, state_d;
  logic [1:0]    act_q;
  logic [5:0]    hidx_q;
  logic [AW-1:0] addr_q;
  logic [2:0]    rkind_q;
  logic [3:0]    code_q;
  logic [TW-1:0] cur_q, cur_d, first_q, first_d, ptr_q, ptr_d;
  logic [3:0]    pto_q, pto_d, srun_q, srun_d;
  logic          tracing_q, tracing_d, each_q, each_d, pend_q, pend_d;
  trfps_pkg::res_t res_q, res_d, out_q;
  logic          out_valid_q, out_load;

  // memories
  logic [AW-1:0] hop_mem [MAX_HOPS];
  logic [AW-1:0] cmp_mem [MAX_HOPS];
  logic          hop_we, hop_re, cmp_we, cmp_re;
  logic [IW-1:0] hop_wa, hop_ra, cmp_wa, cmp_ra;
  logic [AW-1:0] hop_wd, hop_rd_q, cmp_rd_q;

  // scratch
  logic [TW-1:0] ttl, ttl1, f, lim7, lo, hi, hidx7, cmp_end7, tmo_end;
  logic [4:0]    pt1, sr1, per5, lim5;
  logic          resp_final_reached;

  assign in_stall_o = (state_q != trfps_pkg::S_IDLE);

  always_ff @(posedge clk_i) begin
    if (hop_we) begin
      hop_mem[hop_wa] <= hop_wd;
    end
    if (hop_re) begin
      hop_rd_q <= hop_mem[hop_ra];
    end
    if (cmp_we) begin
      cmp_mem[cmp_wa] <= addr_q;
    end
    if (cmp_re) begin
      cmp_rd_q <= cmp_mem[cmp_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q <= 4'd3;
      lim_q <= 4'd3;
      start_ttl_q <= 6'd1;
      dest_q <= '0;
      cmp_en_q <= 1'b0;
      cmp_start_q <= 6'd1;
      cmp_end_q <= 6'd0;
      cmp_oc_q <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        trfps_pkg::REG_PROBES_PER_HOP: per_q <= cfg_data_i[3:0];
        trfps_pkg::REG_TIMEOUT_LIMIT:  lim_q <= cfg_data_i[3:0];
        trfps_pkg::REG_START_TTL:      start_ttl_q <= cfg_data_i[5:0];
        trfps_pkg::REG_DEST_ADDR:      dest_q <= cfg_data_i;
        trfps_pkg::REG_CMP_ENABLE:     cmp_en_q <= cfg_data_i[0];
        trfps_pkg::REG_CMP_START:      cmp_start_q <= cfg_data_i[5:0];
        trfps_pkg::REG_CMP_END:        cmp_end_q <= cfg_data_i[5:0];
        trfps_pkg::REG_CMP_OUTCOME:    cmp_oc_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trfps_pkg::S_IDLE;
      cur_q <= '0;
      first_q <= '0;
      ptr_q <= '0;
      pto_q <= '0;
      srun_q <= '0;
      tracing_q <= 1'b0;
      each_q <= 1'b0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      first_q <= first_d;
      ptr_q <= ptr_d;
      pto_q <= pto_d;
      srun_q <= srun_d;
      tracing_q <= tracing_d;
      each_q <= each_d;
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q <= action_i;
      hidx_q <= hop_index_i;
      addr_q <= address_i;
      rkind_q <= response_kind_i;
      code_q <= unreach_code_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_d;
    end
  end

  function automatic trfps_pkg::res_t next_probe(input logic [TW-1:0] nt, input logic pd,
                                                 input logic hv, input logic [TW-1:0] httl,
                                                 input logic [AW-1:0] ha);
    if (nt > MAXH) begin
      return trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, hv, httl, ha,
                               trfps_pkg::OUT_MAXHOP, MAXH);
    end
    return trfps_pkg::mk_res(trfps_pkg::KIND_PROBE, nt, pd, hv, httl, ha,
                             trfps_pkg::OUT_REACHED, '0);
  endfunction

  always_comb begin
    ttl = cur_q;
    ttl1 = cur_q + ONE;
    per5 = (per_q == 4'd0) ? 5'd1 : {1'b0, per_q};
    lim5 = (lim_q == 4'd0) ? 5'd1 : {1'b0, lim_q};
    lim7 = TW'(lim5);
    pt1 = {1'b0, pto_q} + 5'd1;
    sr1 = {1'b0, srun_q} + 5'd1;
    tmo_end = (ttl1 > lim7) ? (ttl1 - lim7) : '0;
    cmp_end7 = TW'(cmp_end_q);
    hidx7 = TW'(hidx_q);
    lo = (cmp_start_q == 6'd0) ? ONE : TW'(cmp_start_q);
    hi = (cmp_end7 > MAXH1) ? MAXH1 : cmp_end7;
    f = (cmp_en_q && start_ttl_q == 6'd0) ? cmp_end7 : TW'(start_ttl_q);
    if (f == '0) begin
      f = ONE;
    end
    resp_final_reached = !(rkind_q == trfps_pkg::RSP_UNREACH &&
                           code_q != trfps_pkg::UNR_PROTOCOL && code_q != trfps_pkg::UNR_PORT);

    state_d = state_q;
    cur_d = cur_q;
    first_d = first_q;
    ptr_d = ptr_q;
    pto_d = pto_q;
    srun_d = srun_q;
    tracing_d = tracing_q;
    each_d = each_q;
    pend_d = pend_q;
    res_d = res_q;
    hop_we = 1'b0;
    hop_wa = IW'(ttl - ONE);
    hop_wd = '0;
    hop_re = 1'b0;
    hop_ra = '0;
    cmp_we = 1'b0;
    cmp_wa = IW'(hidx7 - ONE);
    cmp_re = 1'b0;
    cmp_ra = '0;
    out_load = 1'b0;

    unique case (state_q)
      trfps_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = trfps_pkg::S_EXEC;
        end
      end
      trfps_pkg::S_EXEC: begin
        state_d = trfps_pkg::S_IDLE;
        priority if (act_q == trfps_pkg::ACT_LOAD) begin
          cmp_we = (hidx7 >= ONE) && (hidx7 <= MAXH);
        end else if (act_q == trfps_pkg::ACT_START) begin
          each_d = cmp_en_q && (start_ttl_q != 6'd0);
          first_d = f;
          cur_d = f;
          pto_d = '0;
          srun_d = '0;
          tracing_d = !(f > MAXH);
          res_d = next_probe(f, 1'b1, 1'b0, '0, '0);
          state_d = trfps_pkg::S_EMIT;
        end else if (act_q == trfps_pkg::ACT_RESP && tracing_q) begin
          state_d = trfps_pkg::S_EMIT;
          priority if (rkind_q >= trfps_pkg::RSP_FAIL) begin
            tracing_d = 1'b0;
            res_d = trfps_pkg::mk_res(trfps_pkg::KIND_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                      trfps_pkg::OUT_REACHED, '0);
          end else if (rkind_q == trfps_pkg::RSP_TIMEOUT) begin
            pto_d = pt1[3:0];
            if (cmp_en_q && !each_q && cmp_end7 == ttl &&
                cmp_oc_q == trfps_pkg::OUT_TIMEOUT) begin
              hop_we = 1'b1;
              tracing_d = 1'b0;
              res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, '0,
                                        trfps_pkg::OUT_TIMEOUT, ttl);
            end else if (pt1 >= per5) begin
              pto_d = '0;
              srun_d = sr1[3:0];
              hop_we = 1'b1;
              if (sr1 >= lim5) begin
                tracing_d = 1'b0;
                res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, '0,
                                          trfps_pkg::OUT_TIMEOUT, tmo_end);
              end else begin
                cur_d = ttl1;
                tracing_d = !(ttl1 > MAXH);
                res_d = next_probe(ttl1, 1'b0, 1'b1, ttl, '0);
              end
            end else begin
              res_d = next_probe(ttl, 1'b0, 1'b0, '0, '0);
            end
          end else begin
            pto_d = '0;
            srun_d = '0;
            hop_we = 1'b1;
            hop_wd = addr_q;
            if (rkind_q == trfps_pkg::RSP_EXCEEDED) begin
              if (ttl > TWO) begin
                hop_re = 1'b1;
                hop_ra = IW'(ttl - TWO);
                state_d = trfps_pkg::S_PREV;
              end else begin
                state_d = trfps_pkg::S_DEST;
              end
            end else begin
              tracing_d = 1'b0;
              res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, addr_q,
                                        resp_final_reached ? trfps_pkg::OUT_REACHED
                                                           : trfps_pkg::OUT_UNREACH, ttl);
            end
          end
        end else begin
          state_d = trfps_pkg::S_IDLE;
        end
      end
      trfps_pkg::S_PREV: begin
        ptr_d = first_q;
        pend_d = 1'b0;
        state_d = (addr_q != hop_rd_q) ? trfps_pkg::S_LOOP : trfps_pkg::S_DEST;
      end
      trfps_pkg::S_LOOP: begin
        priority if (pend_q && addr_q == hop_rd_q) begin
          pend_d = 1'b0;
          tracing_d = 1'b0;
          res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, addr_q,
                                    trfps_pkg::OUT_LOOP, ttl);
          state_d = trfps_pkg::S_EMIT;
        end else if (ptr_q + ONE < ttl) begin
          hop_re = 1'b1;
          hop_ra = IW'(ptr_q - ONE);
          ptr_d = ptr_q + ONE;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          state_d = trfps_pkg::S_DEST;
        end
      end
      trfps_pkg::S_DEST: begin
        state_d = trfps_pkg::S_EMIT;
        priority if (addr_q == dest_q) begin
          tracing_d = 1'b0;
          res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, addr_q,
                                    trfps_pkg::OUT_FAKE, ttl);
        end else if (cmp_en_q && each_q) begin
          ptr_d = lo;
          pend_d = 1'b0;
          state_d = trfps_pkg::S_CMP;
        end else if (cmp_en_q && cmp_oc_q == trfps_pkg::OUT_LOOP && cmp_end7 == ttl) begin
          cmp_re = 1'b1;
          cmp_ra = IW'(ttl - ONE);
          state_d = trfps_pkg::S_ONE_CHK;
        end else begin
          cur_d = ttl1;
          tracing_d = !(ttl1 > MAXH);
          res_d = next_probe(ttl1, 1'b1, 1'b1, ttl, addr_q);
        end
      end
      trfps_pkg::S_CMP: begin
        priority if (pend_q && addr_q == cmp_rd_q) begin
          pend_d = 1'b0;
          tracing_d = 1'b0;
          res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, addr_q,
                                    trfps_pkg::OUT_MEETS, ttl);
          state_d = trfps_pkg::S_EMIT;
        end else if (ptr_q < hi) begin
          cmp_re = 1'b1;
          cmp_ra = IW'(ptr_q - ONE);
          ptr_d = ptr_q + ONE;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          cur_d = ttl1;
          tracing_d = !(ttl1 > MAXH);
          res_d = next_probe(ttl1, 1'b1, 1'b1, ttl, addr_q);
          state_d = trfps_pkg::S_EMIT;
        end
      end
      trfps_pkg::S_ONE_CHK: begin
        state_d = trfps_pkg::S_EMIT;
        if (cmp_rd_q == addr_q) begin
          tracing_d = 1'b0;
          res_d = trfps_pkg::mk_res(trfps_pkg::KIND_DONE, '0, 1'b0, 1'b1, ttl, addr_q,
                                    trfps_pkg::OUT_LOOP, ttl);
        end else begin
          cur_d = ttl1;
          tracing_d = !(ttl1 > MAXH);
          res_d = next_probe(ttl1, 1'b1, 1'b1, ttl, addr_q);
        end
      end
      trfps_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = trfps_pkg::S_IDLE;
        end
      end
      default: state_d = trfps_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = out_q.kind;
  assign probe_ttl_o = out_q.probe_ttl;
  assign probe_to_dest_o = out_q.probe_to_dest;
  assign hop_valid_o = out_q.hop_valid;
  assign hop_ttl_o = out_q.hop_ttl;
  assign hop_address_o = out_q.hop_address;
  assign outcome_o = out_q.outcome;
  assign end_ttl_o = out_q.end_ttl;

endmodule

`default_nettype wire
